### design/button_click_classifier_top_defines.svh
// assertion macros for the button click classifier
// used by bcc_core and button_click_classifier_top
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BCC_ASSERT(label, clk, rst, prop, msg)
`define BCC_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### design/bcc_pkg.sv
// shared types and constants of the button click classifier
// no dependencies
package bcc_pkg;

   localparam int CFG_WIDTH   = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 8;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_PRESSED = 2'd1;
   localparam logic [1:0] MODE_WAIT    = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SINGLE = 2'd1;
   localparam logic [1:0] EV_DOUBLE = 2'd2;
   localparam logic [1:0] EV_LONG   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE   = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] DOUBLE_RESET   = 16'd300;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_WIDTH-1:0] data;
   } csr_wr_type;

endpackage

### design/bcc_core.sv
// classifier state, settings registers and per-tick update logic
// depends on bcc_pkg and button_click_classifier_top_defines.svh
`include "button_click_classifier_top_defines.svh"

module bcc_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  bcc_pkg::csr_wr_type csr_wr,
   input  logic                step_en,
   input  logic                level,
   output logic [1:0]          event_code
);

   localparam int CMP_W = (COUNT_WIDTH > bcc_pkg::CFG_WIDTH) ? COUNT_WIDTH : bcc_pkg::CFG_WIDTH;

   logic [bcc_pkg::CFG_WIDTH-1:0] debounce_ff;
   logic [bcc_pkg::CFG_WIDTH-1:0] long_ff;
   logic [bcc_pkg::CFG_WIDTH-1:0] double_ff;

   logic [1:0]             mode_ff, mode_in;
   logic                   last_level_ff, last_level_in;
   logic [COUNT_WIDTH-1:0] since_edge_ff, since_edge_in;
   logic [COUNT_WIDTH-1:0] since_press_ff, since_press_in;
   logic [COUNT_WIDTH-1:0] since_release_ff, since_release_in;
   logic                   long_reported_ff, long_reported_in;

   logic [COUNT_WIDTH-1:0] edge_inc, press_inc, release_inc;
   logic                   edge_ok, press_edge, release_edge, double_hit;
   logic [1:0]             ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= bcc_pkg::DEBOUNCE_RESET;
         long_ff     <= bcc_pkg::LONG_RESET;
         double_ff   <= bcc_pkg::DOUBLE_RESET;
      end else if (csr_wr.valid) begin
         case (csr_wr.index)
            bcc_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wr.data;
            bcc_pkg::CSR_LONG:     long_ff     <= csr_wr.data;
            bcc_pkg::CSR_DOUBLE:   double_ff   <= csr_wr.data;
            default: ;
         endcase
      end
   end

   // saturating elapsed counters
   assign edge_inc    = (&since_edge_ff)    ? since_edge_ff    : since_edge_ff + COUNT_WIDTH'(1);
   assign press_inc   = (&since_press_ff)   ? since_press_ff   : since_press_ff + COUNT_WIDTH'(1);
   assign release_inc = (&since_release_ff) ? since_release_ff
                                            : since_release_ff + COUNT_WIDTH'(1);

   assign edge_ok      = (level != last_level_ff) && (CMP_W'(edge_inc) >= CMP_W'(debounce_ff));
   assign press_edge   = edge_ok && !level;
   assign release_edge = edge_ok && level;

   always_comb begin
      mode_in          = mode_ff;
      last_level_in    = edge_ok ? level : last_level_ff;
      since_edge_in    = edge_ok ? '0 : edge_inc;
      since_press_in   = press_inc;
      since_release_in = release_inc;
      long_reported_in = long_reported_ff;
      double_hit       = 1'b0;
      ev               = bcc_pkg::EV_NONE;
      if (press_edge) begin
         if (mode_ff == bcc_pkg::MODE_WAIT) begin
            mode_in    = bcc_pkg::MODE_IDLE;
            double_hit = 1'b1;
            ev         = bcc_pkg::EV_DOUBLE;
         end else if (mode_ff != bcc_pkg::MODE_PRESSED) begin
            mode_in          = bcc_pkg::MODE_PRESSED;
            since_press_in   = '0;
            long_reported_in = 1'b0;
         end
      end
      if (!double_hit) begin
         if (release_edge && mode_in == bcc_pkg::MODE_PRESSED) begin
            if (CMP_W'(since_press_in) >= CMP_W'(long_ff)) begin
               mode_in = bcc_pkg::MODE_IDLE;
            end else begin
               mode_in          = bcc_pkg::MODE_WAIT;
               since_release_in = '0;
            end
         end
         if (mode_in == bcc_pkg::MODE_PRESSED && !long_reported_in &&
             CMP_W'(since_press_in) >= CMP_W'(long_ff)) begin
            long_reported_in = 1'b1;
            ev               = bcc_pkg::EV_LONG;
         end
         if (mode_in == bcc_pkg::MODE_WAIT &&
             CMP_W'(since_release_in) >= CMP_W'(double_ff)) begin
            mode_in = bcc_pkg::MODE_IDLE;
            ev      = bcc_pkg::EV_SINGLE;
         end
      end
   end

   assign event_code = ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= bcc_pkg::MODE_IDLE;
         last_level_ff    <= 1'b1;
         since_edge_ff    <= '0;
         since_press_ff   <= '0;
         since_release_ff <= '0;
         long_reported_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff          <= mode_in;
         last_level_ff    <= last_level_in;
         since_edge_ff    <= since_edge_in;
         since_press_ff   <= since_press_in;
         since_release_ff <= since_release_in;
         long_reported_ff <= long_reported_in;
      end
   end

   `BCC_ASSERT_NEVER(a_mode_legal, clock, reset, mode_ff == bcc_pkg::MODE_UNUSED, "unused mode reached")
   `BCC_ASSERT(a_long_marks, clock, reset, step_en && ev == bcc_pkg::EV_LONG |=> long_reported_ff, "long press not marked")
   `BCC_ASSERT(a_double_idle, clock, reset, step_en && ev == bcc_pkg::EV_DOUBLE |=> mode_ff == bcc_pkg::MODE_IDLE, "double click left mode busy")
   `BCC_ASSERT(a_single_idle, clock, reset, step_en && ev == bcc_pkg::EV_SINGLE |=> mode_ff == bcc_pkg::MODE_IDLE, "single click left mode busy")

endmodule

### design/button_click_classifier_top.sv
// top level of the button click classifier: input register, classifier core, result register
// depends on bcc_pkg, bcc_core and button_click_classifier_top_defines.svh
//
// Usage:
//   req channel: one tick item per transfer, req_tdata[0] is the sampled
//   button level (0 pressed, 1 released).
//   rsp channel: one event code per tick item, rsp_tdata[1:0]
//   (0 none, 1 single click, 2 double click, 3 long press).
//   csr channel: csr_index 0 debounce, 1 long press, 2 double click window,
//   all in ticks; index 3 is ignored; csr_ready is always high.
//   Path: an accepted item waits in the input register; its event is computed
//   in the core and captured in the result register. Throughput: one item per
//   cycle unless rsp stalls, set by the single update pass between the registers.
//   Reset: synchronous; clears the valid bits of both registers, the classifier state and
//   restores the settings to 50, 1000 and 300.
//   Stall: while rsp_tready is low the result holds, the input register
//   keeps one more item, and req_tready then falls until the result moves.
//
`include "button_click_classifier_top_defines.svh"

module button_click_classifier_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bcc_pkg::REQ_TDATA_W-1:0]      req_tdata,   // [0] button_level
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bcc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,   // [1:0] event_code
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bcc_pkg::CFG_WIDTH-1:0]        csr_data
);

   logic                in_valid_ff;
   logic                level_ff;
   logic                rsp_valid_ff;
   logic [1:0]          event_ff;
   logic                out_free, step_en;
   logic [1:0]          core_event;
   bcc_pkg::csr_wr_type csr_wr;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         level_ff <= req_tdata[0];
      end
   end

   bcc_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_wr),
      .step_en    (step_en),
      .level      (level_ff),
      .event_code (core_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         event_ff <= core_event;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(bcc_pkg::RSP_TDATA_W - 2)'(0), event_ff};

   `BCC_ASSERT(a_item_advances, clock, reset, in_valid_ff && !rsp_valid_ff |=> rsp_valid_ff, "held item did not reach result register")

endmodule
